@@ src/tvpf_pkg.sv @@
// Shared constants for the typed value packet framer.
package tvpf_pkg;

  localparam int AddrW      = 5;
  localparam int DataW      = 32;
  localparam int CountW     = 5;
  localparam int NumKinds   = 5;
  localparam int ResultsMax = 7;
  localparam int RemW       = 3;

  localparam logic [7:0] HeadByte = 8'hA5;
  localparam logic [7:0] TailByte = 8'h5A;

  // register indexes (byte address / 4)
  localparam logic [2:0] RegBoolCount  = 3'd0;
  localparam logic [2:0] RegByteCount  = 3'd1;
  localparam logic [2:0] RegShortCount = 3'd2;
  localparam logic [2:0] RegIntCount   = 3'd3;
  localparam logic [2:0] RegFloatCount = 3'd4;

  localparam logic [CountW-1:0] BoolCountRst  = 5'd0;
  localparam logic [CountW-1:0] ByteCountRst  = 5'd0;
  localparam logic [CountW-1:0] ShortCountRst = 5'd0;
  localparam logic [CountW-1:0] IntCountRst   = 5'd0;
  localparam logic [CountW-1:0] FloatCountRst = 5'd1;

  typedef enum logic [2:0] {
    KindBool  = 3'd0,
    KindByte  = 3'd1,
    KindShort = 3'd2,
    KindInt   = 3'd3,
    KindFloat = 3'd4
  } kind_e;

endpackage

@@ src/typed_value_packet_framer_top.sv @@
// Typed value packet framer: values in, framed byte stream with checksum out.
// Each accepted input transfer is turned into its run of output bytes
// (head if first, 0/1/2/4 payload bytes, checksum and tail if last: up to seven),
// which sits in a shift buffer and leaves at one byte per cycle while out_ready_i
// is high. A new value is taken while the final byte of the previous run leaves,
// so the sustained rate is set by the output port. Payload is four bytes for an
// int or float, two for a short and one for a byte; bools are packed eight to a
// byte. Each packet adds a head byte, a checksum byte and a tail byte.
// Counts above MAX_PER_KIND are clamped; with all counts zero values are
// consumed and dropped. Any register write restarts the packet.
module typed_value_packet_framer_top #(
  parameter int MAX_PER_KIND = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [31:0]                value_bits_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [7:0]                 out_byte_o,
  output logic                       end_of_packet_o,
  output logic                       last_of_run_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [tvpf_pkg::AddrW-1:0] paddr,
  input  logic [tvpf_pkg::DataW-1:0] pwdata,
  output logic [tvpf_pkg::DataW-1:0] prdata,
  output logic                       pready
);
  import tvpf_pkg::*;

  localparam int MaxClamp = (MAX_PER_KIND > 31) ? 31 : MAX_PER_KIND;
  localparam int PosW     = $clog2(NumKinds * MaxClamp + 1);

  logic [CountW-1:0] cnt_q [NumKinds];
  logic [CountW-1:0] eff   [NumKinds];
  logic [PosW-1:0]   end_pos [NumKinds];
  logic [PosW-1:0]   total;

  logic [PosW-1:0] pos_q, pos_d;
  logic [7:0]      sum_q, sum_d;
  logic [7:0]      acc_q, acc_d;
  logic [2:0]      bp_q, bp_d;

  logic [7:0]      buf_q [ResultsMax];
  logic [7:0]      run   [ResultsMax];
  logic [RemW-1:0] rem_q, nb;
  logic            tail_q;

  logic            cfg_wr, in_accept, out_take, active;
  logic            restart, first, endp, bool_flush;
  logic [PosW-1:0] pos_c, pos_inc;
  logic [7:0]      sum_c, acc_c, acc_new, sum_new;
  logic [2:0]      bp_c;
  logic [2:0]      npay;
  logic [7:0]      pay [4];
  kind_e           kind;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q[0] <= BoolCountRst;
      cnt_q[1] <= ByteCountRst;
      cnt_q[2] <= ShortCountRst;
      cnt_q[3] <= IntCountRst;
      cnt_q[4] <= FloatCountRst;
    end else if (cfg_wr) begin
      case (paddr[AddrW-1:2])
        RegBoolCount:  cnt_q[0] <= pwdata[CountW-1:0];
        RegByteCount:  cnt_q[1] <= pwdata[CountW-1:0];
        RegShortCount: cnt_q[2] <= pwdata[CountW-1:0];
        RegIntCount:   cnt_q[3] <= pwdata[CountW-1:0];
        RegFloatCount: cnt_q[4] <= pwdata[CountW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[AddrW-1:2])
      RegBoolCount:  prdata = DataW'(cnt_q[0]);
      RegByteCount:  prdata = DataW'(cnt_q[1]);
      RegShortCount: prdata = DataW'(cnt_q[2]);
      RegIntCount:   prdata = DataW'(cnt_q[3]);
      RegFloatCount: prdata = DataW'(cnt_q[4]);
      default:       prdata = '0;
    endcase
  end

  // clamped counts and the end position of each kind's section
  always_comb begin
    for (int k = 0; k < NumKinds; k++) begin
      eff[k] = (cnt_q[k] > CountW'(MaxClamp)) ? CountW'(MaxClamp) : cnt_q[k];
    end
    end_pos[0] = PosW'(eff[0]);
    for (int k = 1; k < NumKinds; k++) begin
      end_pos[k] = end_pos[k-1] + PosW'(eff[k]);
    end
    total = end_pos[NumKinds-1];
  end

  // handshakes
  assign out_valid_o = (rem_q != '0);
  assign out_take    = out_valid_o & out_ready_i;
  assign in_ready_o  = (rem_q == '0) || ((rem_q == RemW'(1)) && out_ready_i);
  assign in_accept   = in_valid_i & in_ready_o;
  assign active      = (total != '0);

  // byte run for one value
  always_comb begin
    restart = (pos_q >= total);
    first   = (pos_q == '0) || restart;
    pos_c   = restart ? '0 : pos_q;
    sum_c   = restart ? '0 : sum_q;
    acc_c   = restart ? '0 : acc_q;
    bp_c    = restart ? '0 : bp_q;
    pos_inc = pos_c + PosW'(1);
    endp    = (pos_inc >= total);

    if (pos_c < end_pos[0])      kind = KindBool;
    else if (pos_c < end_pos[1]) kind = KindByte;
    else if (pos_c < end_pos[2]) kind = KindShort;
    else if (pos_c < end_pos[3]) kind = KindInt;
    else                         kind = KindFloat;

    acc_new    = acc_c | (8'(value_bits_i != '0) << bp_c);
    bool_flush = (bp_c == 3'd7) || (pos_inc == end_pos[0]);

    case (kind)
      KindBool:  npay = bool_flush ? 3'd1 : 3'd0;
      KindByte:  npay = 3'd1;
      KindShort: npay = 3'd2;
      KindInt:   npay = 3'd4;
      KindFloat: npay = 3'd4;
      default:   npay = 3'd0;
    endcase

    pay[0] = (kind == KindBool) ? acc_new : value_bits_i[7:0];
    pay[1] = value_bits_i[15:8];
    pay[2] = value_bits_i[23:16];
    pay[3] = value_bits_i[31:24];

    sum_new = sum_c;
    for (int j = 0; j < 4; j++) begin
      if (3'(j) < npay) sum_new = sum_new + pay[j];
    end

    for (int i = 0; i < ResultsMax; i++) run[i] = '0;
    nb = '0;
    if (first) begin
      run[nb] = HeadByte;
      nb      = nb + RemW'(1);
    end
    for (int j = 0; j < 4; j++) begin
      if (3'(j) < npay) begin
        run[nb] = pay[j];
        nb      = nb + RemW'(1);
      end
    end
    if (endp) begin
      run[nb] = sum_new;
      nb      = nb + RemW'(1);
      run[nb] = TailByte;
      nb      = nb + RemW'(1);
    end

    pos_d = endp ? '0 : pos_inc;
    sum_d = endp ? '0 : sum_new;
    acc_d = acc_c;
    bp_d  = bp_c;
    if (kind == KindBool) begin
      acc_d = bool_flush ? '0 : acc_new;
      bp_d  = bool_flush ? '0 : bp_c + 3'd1;
    end
    if (endp) begin
      acc_d = '0;
      bp_d  = '0;
    end
  end

  // packet state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      sum_q <= '0;
      acc_q <= '0;
      bp_q  <= '0;
    end else if (cfg_wr) begin
      pos_q <= '0;
      sum_q <= '0;
      acc_q <= '0;
      bp_q  <= '0;
    end else if (in_accept && active) begin
      pos_q <= pos_d;
      sum_q <= sum_d;
      acc_q <= acc_d;
      bp_q  <= bp_d;
    end
  end

  // output shift buffer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      tail_q <= 1'b0;
    end else if (in_accept) begin
      rem_q  <= active ? nb : '0;
      tail_q <= active & endp;
    end else if (out_take) begin
      rem_q  <= rem_q - RemW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      buf_q <= run;
    end else if (out_take) begin
      for (int i = 0; i < ResultsMax - 1; i++) buf_q[i] <= buf_q[i+1];
    end
  end

  assign out_byte_o      = buf_q[0];
  assign last_of_run_o   = (rem_q == RemW'(1));
  assign end_of_packet_o = last_of_run_o & tail_q;

  a_eop_is_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && end_of_packet_o |-> out_byte_o == TailByte)
    else $error("end of packet on a byte other than the tail");

  a_eop_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    end_of_packet_o |-> last_of_run_o)
    else $error("end of packet before end of run");

  a_idle_no_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && !active |=> !out_valid_o)
    else $error("output produced with all counts zero");

  a_bool_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bp_q != '0 |-> pos_q < end_pos[0])
    else $error("partial bool byte outside the bool section");

endmodule

@@ test/tb_typed_value_packet_framer_top.sv @@
// Testbench for the typed value packet framer: APB count setup, value stream in, framed bytes checked.
`timescale 1ns / 100ps

module tb_typed_value_packet_framer_top;
  import tvpf_pkg::*;

  localparam int MaxPerKind   = 16;
  localparam int SettleCycles = 16;
  localparam int HoldCycles   = 400;
  localparam int MaxCycles    = 200000;

  localparam logic [2:0] RegSpareLo = 3'd5;
  localparam logic [2:0] RegBeyond  = 3'd6;
  localparam logic [2:0] RegSpareHi = 3'd7;

  typedef struct packed {
    logic [7:0] data;
    logic       eop;
    logic       last;
  } out_beat_t;

  typedef enum logic [1:0] {RxFree, RxRandom, RxPattern} rx_mode_e;

  logic               clk_i        = 1'b0;
  logic               rst_ni       = 1'b0;
  logic               in_valid_i   = 1'b0;
  logic               in_ready_o;
  logic [31:0]        value_bits_i = '0;
  logic               out_valid_o;
  logic               out_ready_i  = 1'b0;
  logic [7:0]         out_byte_o;
  logic               end_of_packet_o;
  logic               last_of_run_o;
  logic               psel         = 1'b0;
  logic               penable      = 1'b0;
  logic               pwrite       = 1'b0;
  logic [AddrW-1:0]   paddr        = '0;
  logic [DataW-1:0]   pwdata       = '0;
  logic [DataW-1:0]   prdata;
  logic               pready;

  // predictor state
  logic [CountW-1:0]  count_q [NumKinds];
  int                 value_pos;
  logic [7:0]         bool_acc;
  int                 bool_bit;
  logic [7:0]         sum_q;
  out_beat_t          run_q[$];
  out_beat_t          frame_bytes_q[$];

  int                 mismatch_count = 0;
  int                 cycle_count    = 0;

  // pacing
  bit                 sender_bursty = 1'b0;
  int                 burst_left    = 0;
  rx_mode_e           rx_mode       = RxFree;
  bit                 hold_req      = 1'b0;
  int                 hold_left     = 0;
  int                 stall_phase   = 0;

  typed_value_packet_framer_top #(
    .MAX_PER_KIND(MaxPerKind)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .value_bits_i   (value_bits_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_byte_o     (out_byte_o),
    .end_of_packet_o(end_of_packet_o),
    .last_of_run_o  (last_of_run_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > MaxCycles) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  function automatic int clamped(input int k);
    return (int'(count_q[k]) > MaxPerKind) ? MaxPerKind : int'(count_q[k]);
  endfunction

  function automatic int kind_width(input kind_e kind);
    case (kind)
      KindByte:            return 1;
      KindShort:           return 2;
      KindInt, KindFloat:  return 4;
      default:             return 0;
    endcase
  endfunction

  function automatic void clear_packet();
    value_pos = 0;
    bool_acc  = '0;
    bool_bit  = 0;
    sum_q     = '0;
  endfunction

  function automatic void reset_frame_model();
    count_q[RegBoolCount]  = BoolCountRst;
    count_q[RegByteCount]  = ByteCountRst;
    count_q[RegShortCount] = ShortCountRst;
    count_q[RegIntCount]   = IntCountRst;
    count_q[RegFloatCount] = FloatCountRst;
    clear_packet();
    frame_bytes_q.delete();
  endfunction

  function automatic void apply_count_write(input logic [2:0] idx, input logic [DataW-1:0] data);
    if (int'(idx) < NumKinds) count_q[idx] = data[CountW-1:0];
    clear_packet();
  endfunction

  function automatic void push_beat(input logic [7:0] data, input logic eop);
    run_q.push_back({data, eop, 1'b0});
  endfunction

  function automatic void push_payload(input logic [7:0] data);
    sum_q = sum_q + data;
    push_beat(data, 1'b0);
  endfunction

  function automatic void frame_value(input logic [31:0] v);
    int        total;
    int        p;
    int        k;
    int        b;
    out_beat_t beat;
    total = 0;
    for (k = 0; k < NumKinds; k++) total += clamped(k);
    if (total == 0) return;
    if (value_pos >= total) clear_packet();
    run_q.delete();
    if (value_pos == 0) push_beat(HeadByte, 1'b0);
    p = value_pos;
    k = 0;
    while (k < NumKinds && p >= clamped(k)) begin
      p -= clamped(k);
      k++;
    end
    if (k == int'(KindBool)) begin
      if (v != 0) bool_acc[bool_bit] = 1'b1;
      if (bool_bit == 7 || p + 1 == clamped(int'(KindBool))) begin
        push_payload(bool_acc);
        bool_acc = '0;
        bool_bit = 0;
      end else begin
        bool_bit++;
      end
    end else begin
      for (b = 0; b < kind_width(kind_e'(k)); b++) push_payload(v[8*b +: 8]);
    end
    value_pos++;
    if (value_pos >= total) begin
      push_beat(sum_q, 1'b0);
      push_beat(TailByte, 1'b1);
      clear_packet();
    end
    for (b = 0; b < run_q.size(); b++) begin
      beat = run_q[b];
      beat.last = (b == run_q.size() - 1);
      frame_bytes_q.push_back(beat);
    end
  endfunction

  // one process follows config writes, input transfers and output transfers
  always @(posedge clk_i) begin : frame_monitor
    out_beat_t seen;
    out_beat_t want;
    if (!rst_ni) begin
      reset_frame_model();
    end else begin
      if (psel && penable && pwrite && pready) apply_count_write(paddr[AddrW-1:2], pwdata);
      if (in_valid_i && in_ready_o) frame_value(value_bits_i);
      if (out_valid_o && out_ready_i) begin
        seen = {out_byte_o, end_of_packet_o, last_of_run_o};
        if (frame_bytes_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("framer: unexpected byte %h eop %b last %b", seen.data, seen.eop, seen.last);
        end else begin
          want = frame_bytes_q.pop_front();
          if (seen !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("framer: expected byte %h eop %b last %b, got byte %h eop %b last %b",
                       want.data, want.eop, want.last, seen.data, seen.eop, seen.last);
          end
        end
      end
    end
  end

  // receiver stall pattern, with an optional long hold-off
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_left = HoldCycles;
      hold_req  = 1'b0;
    end
    stall_phase = (stall_phase == 6) ? 0 : stall_phase + 1;
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      case (rx_mode)
        RxFree:    out_ready_i <= 1'b1;
        RxRandom:  out_ready_i <= ($urandom_range(0, 99) < 55);
        default:   out_ready_i <= (stall_phase >= 2);
      endcase
    end
  end

  // ---------------------------------------------------------------- drivers

  task automatic send_value(input logic [31:0] v);
    int gap;
    if (sender_bursty && burst_left == 0) begin
      burst_left = $urandom_range(1, 10);
      gap = $urandom_range(1, 8);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    if (burst_left != 0) burst_left--;
    in_valid_i   <= 1'b1;
    value_bits_i <= v;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic wait_for_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (frame_bytes_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [CountW-1:0] count);
    logic [DataW-1:0] noise;
    noise = $urandom();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {noise[DataW-1:CountW], count};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_counts(input logic [4:0] n_bool, input logic [4:0] n_byte,
                            input logic [4:0] n_short, input logic [4:0] n_int,
                            input logic [4:0] n_float);
    wait_for_idle();
    write_reg(RegBoolCount, n_bool);
    write_reg(RegByteCount, n_byte);
    write_reg(RegShortCount, n_short);
    write_reg(RegIntCount, n_int);
    write_reg(RegFloatCount, n_float);
  endtask

  task automatic set_pacing();
    sender_bursty = ($urandom_range(0, 2) != 0);
    burst_left    = 0;
    rx_mode       = rx_mode_e'($urandom_range(0, 2));
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return 32'h1 << $urandom_range(0, 31);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [4:0] rand_count();
    return ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(0, 3));
  endfunction

  task automatic send_random(input int n);
    repeat (n) send_value(rand_value());
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_reset_defaults();
    set_pacing();
    send_value(32'hFFFF_FFFF);
    send_value(32'h0000_0000);
    send_value(32'h8000_0001);
  endtask

  task automatic test_mixed_packet();
    set_counts(5'd3, 5'd1, 5'd1, 5'd1, 5'd1);
    set_pacing();
    send_value(32'h0000_0000);
    send_value(32'h8000_0000);
    send_value(32'h0000_0001);
    send_value(32'hFFFF_FF00);
    send_value(32'h1234_FFFF);
    send_value(32'hFFFF_FFFF);
    send_value(32'h3F80_0000);
  endtask

  // nine bools: one full byte then a partial one
  task automatic test_bool_packing();
    set_counts(5'd9, 5'd0, 5'd0, 5'd0, 5'd0);
    set_pacing();
    send_value(32'h0000_0001);
    send_value(32'h0000_0000);
    send_value(32'h0000_0004);
    send_value(32'h0000_0000);
    send_value(32'h0000_0000);
    send_value(32'h0000_0010);
    send_value(32'h0000_0000);
    send_value(32'hFFFF_FFFF);
    send_value(32'h0000_0002);
  endtask

  task automatic test_counts_zero();
    set_counts(5'd0, 5'd0, 5'd0, 5'd0, 5'd0);
    send_random(2);
  endtask

  task automatic test_abandoned_packet();
    set_counts(5'd0, 5'd0, 5'd0, 5'd2, 5'd0);
    send_value(32'hDEAD_BEEF);
    wait_for_idle();
    write_reg(RegBeyond, 5'($urandom()));
    send_value(32'h0102_0304);
    send_value(32'hFFFF_FFFF);
  endtask

  task automatic test_count_clamp();
    set_counts(5'd31, 5'd0, 5'd17, 5'd0, 5'd0);
    set_pacing();
    send_random(45);
    set_counts(5'd31, 5'd31, 5'd31, 5'd31, 5'd31);
    set_pacing();
    send_random(90);
    set_counts(5'd16, 5'd16, 5'd16, 5'd16, 5'd16);
    set_pacing();
    send_random(50);
  endtask

  task automatic test_random_counts();
    logic [4:0] n [NumKinds];
    repeat (6) begin
      foreach (n[k]) n[k] = rand_count();
      if ((n[0] | n[1] | n[2] | n[3] | n[4]) == '0) n[KindFloat] = 5'd1;
      set_counts(n[KindBool], n[KindByte], n[KindShort], n[KindInt], n[KindFloat]);
      if ($urandom_range(0, 2) == 0) write_reg(3'($urandom_range(RegSpareLo, RegSpareHi)), 5'($urandom()));
      set_pacing();
      send_random(30);
    end
  endtask

  // receiver holds off while the sender keeps pushing, so the input stalls
  task automatic test_backpressure();
    set_counts(5'd0, 5'd0, 5'd0, 5'd3, 5'd3);
    sender_bursty = 1'b0;
    rx_mode       = RxFree;
    hold_req      = 1'b1;
    send_random(40);
    wait_for_idle();
    set_pacing();
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_mixed_packet();
    test_bool_packing();
    test_counts_zero();
    test_abandoned_packet();
    test_count_clamp();
    test_random_counts();
    test_backpressure();
    wait_for_idle();
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
